// File: rtl/lfr_pkg.sv
// lfr_pkg: sizes, command codes and sequencer states of the crlf line framer
// no dependencies; used by the controller and the top level
package lfr_pkg;

    localparam int LINE_BYTES = 64;
    localparam int SLOTS      = 4;

    localparam int OFS_W     = $clog2(LINE_BYTES);
    localparam int CNT_W     = $clog2(LINE_BYTES + 1);
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W     = $clog2(SLOTS + 1);
    localparam int ADDR_W    = ROW_W + OFS_W;
    localparam int MEM_DEPTH = (SLOTS + 1) << OFS_W;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_STREAM
    } lfr_state_t;

endpackage

// File: rtl/lfr_if.sv
// lfr_req_if / lfr_rsp_if: valid-ready channels of the crlf line framer
// depends on nothing but plain logic types
interface lfr_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface lfr_rsp_if;
    logic       valid;
    logic       ready;
    logic       has_data;
    logic [7:0] line_byte;
    logic       last_byte;
    logic [1:0] slot_index;

    modport source (output valid, output has_data, output line_byte,
                    output last_byte, output slot_index, input ready);
    modport sink   (input valid, input has_data, input line_byte,
                    input last_byte, input slot_index, output ready);
endinterface

// File: rtl/lfr_ram.sv
// lfr_ram: simple dual-port synchronous ram, one write and one registered read
// generic; no package dependency
module lfr_ram #(
    parameter int DEPTH = 320,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lfr_ctrl.sv
// lfr_ctrl: byte intake, row mapping of slots, ready marks and fetch sequencer
// depends on lfr_pkg, lfr_req_if, lfr_rsp_if; drives the ports of lfr_ram
module lfr_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    lfr_req_if.sink                    req,
    lfr_rsp_if.source                  rsp,
    output logic                       mem_we,
    output logic [lfr_pkg::ADDR_W-1:0] mem_waddr,
    output logic [7:0]                 mem_wdata,
    output logic                       mem_re,
    output logic [lfr_pkg::ADDR_W-1:0] mem_raddr,
    input  logic [7:0]                 mem_rdata
);
    import lfr_pkg::*;

    lfr_state_t state_reg, state_next;

    logic [ROW_W-1:0]  line_row_reg, line_row_next;
    logic [ROW_W-1:0]  slot_row_reg [SLOTS];
    logic [ROW_W-1:0]  slot_row_next [SLOTS];
    logic [CNT_W-1:0]  slot_len_reg [SLOTS];
    logic [CNT_W-1:0]  slot_len_next [SLOTS];
    logic [SLOTS-1:0]  slot_ready_reg, slot_ready_next;
    logic [SLOT_W-1:0] next_slot_reg, next_slot_next;
    logic [CNT_W-1:0]  line_count_reg, line_count_next;
    logic [7:0]        prior_reg, prior_next;

    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  rd_k_reg, rd_k_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_has_reg, out_has_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic [1:0]        out_slot_reg, out_slot_next;

    logic              acc;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              out_free;
    logic              move;
    logic              rd_en;
    logic              close_line;

    // lowest-numbered ready slot
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slot_ready_reg[i])
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign acc        = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign move       = pend_reg && out_free;
    assign rd_en      = (state_reg == ST_STREAM) && (rd_k_reg < len_reg)
                        && (!pend_reg || move);
    assign close_line = acc && (req.command == CMD_BYTE) && (req.rx_byte == BYTE_LF)
                        && (prior_reg == BYTE_CR);

    assign mem_we    = acc && (req.command == CMD_BYTE) && !close_line
                       && (line_count_reg < CNT_W'(LINE_BYTES));
    assign mem_waddr = {line_row_reg, line_count_reg[OFS_W-1:0]};
    assign mem_wdata = req.rx_byte;
    assign mem_re    = rd_en;
    assign mem_raddr = {slot_row_reg[cur_slot_reg], rd_k_reg[OFS_W-1:0]};

    always_comb
    begin
        state_next      = state_reg;
        line_row_next   = line_row_reg;
        slot_row_next   = slot_row_reg;
        slot_len_next   = slot_len_reg;
        slot_ready_next = slot_ready_reg;
        next_slot_next  = next_slot_reg;
        line_count_next = line_count_reg;
        prior_next      = prior_reg;
        cur_slot_next   = cur_slot_reg;
        len_next        = len_reg;
        rd_k_next       = rd_k_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg;
        out_has_next    = out_has_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_slot_next   = out_slot_reg;

        // intake: a closing lf swaps the line row with the target slot's row
        if (close_line)
        begin
            slot_row_next[next_slot_reg]   = line_row_reg;
            line_row_next                  = slot_row_reg[next_slot_reg];
            slot_len_next[next_slot_reg]   = line_count_reg;
            slot_ready_next[next_slot_reg] = 1'b1;
            next_slot_next  = (next_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                              : SLOT_W'(next_slot_reg + 1'b1);
            line_count_next = '0;
            prior_next      = '0;
        end
        else if (acc && req.command == CMD_BYTE)
        begin
            if (mem_we)
            begin
                line_count_next = CNT_W'(line_count_reg + 1'b1);
            end
            prior_next = req.rx_byte;
        end

        // read pipeline
        if (rd_en)
        begin
            rd_k_next      = CNT_W'(rd_k_reg + 1'b1);
            pend_next      = 1'b1;
            pend_last_next = (CNT_W'(rd_k_reg + 1'b1) == len_reg);
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end

        // output register
        if (move)
        begin
            out_valid_next = 1'b1;
            out_has_next   = 1'b1;
            out_byte_next  = mem_rdata;
            out_last_next  = pend_last_reg;
            out_slot_next  = 2'(cur_slot_reg);
        end
        else if (state_reg == ST_EMPTY && out_free)
        begin
            out_valid_next = 1'b1;
            out_has_next   = 1'b0;
            out_byte_next  = '0;
            out_last_next  = 1'b0;
            out_slot_next  = '0;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (acc && req.command == CMD_FETCH)
                begin
                    if (hit)
                    begin
                        slot_ready_next[hit_slot] = 1'b0;
                        cur_slot_next = hit_slot;
                        len_next      = slot_len_reg[hit_slot];
                        rd_k_next     = '0;
                        state_next    = ST_STREAM;
                    end
                    else
                    begin
                        state_next = ST_EMPTY;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STREAM:
            begin
                if (rd_k_reg == len_reg && !pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            line_row_reg   <= ROW_W'(SLOTS);
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_row_reg[i] <= ROW_W'(i);
                slot_len_reg[i] <= '0;
            end
            slot_ready_reg <= '0;
            next_slot_reg  <= '0;
            line_count_reg <= '0;
            prior_reg      <= '0;
            cur_slot_reg   <= '0;
            len_reg        <= '0;
            rd_k_reg       <= '0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_row_reg   <= line_row_next;
            slot_row_reg   <= slot_row_next;
            slot_len_reg   <= slot_len_next;
            slot_ready_reg <= slot_ready_next;
            next_slot_reg  <= next_slot_next;
            line_count_reg <= line_count_next;
            prior_reg      <= prior_next;
            cur_slot_reg   <= cur_slot_next;
            len_reg        <= len_next;
            rd_k_reg       <= rd_k_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_has_reg  <= out_has_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_slot_reg <= out_slot_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.has_data   = out_has_reg;
    assign rsp.line_byte  = out_byte_reg;
    assign rsp.last_byte  = out_last_reg;
    assign rsp.slot_index = out_slot_reg;

    // a pending read word is never overwritten before it moves out
    a_no_read_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !move |-> !rd_en)
        else $error("read issued over unconsumed ram data");

    // a fetched slot loses its ready mark
    a_fetch_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        acc && req.command == CMD_FETCH && hit |=> !slot_ready_reg[$past(hit_slot)])
        else $error("fetched slot still ready");

    a_line_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg <= CNT_W'(LINE_BYTES))
        else $error("line count past capacity");

    // intake only resumes once the read pipeline has drained
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_reg)
        else $error("idle with ram read pending");

    // a line reaching a slot is never empty
    a_close_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        close_line |-> line_count_reg != '0)
        else $error("empty line closed");

endmodule

// File: rtl/crlf_line_framer_four_slot_top.sv
// Fetch requests are accepted while the block is idle and then occupy the block
// until the line has left, limited by the single read port of the line buffer
// ram: one byte leaves per cycle while the output is taken, and an empty fetch
// holds the block until its no-data response is registered. Byte requests are
// accepted only while idle too. Lines go into ram rows; ending a line swaps the
// row mapping of the target slot, so no copy takes place. No clearing pass after reset.
// depends on lfr_pkg, lfr_if, lfr_ram and lfr_ctrl
module crlf_line_framer_four_slot_top (
    input  logic      clk,
    input  logic      rst_n,
    lfr_req_if.sink   req,
    lfr_rsp_if.source rsp
);
    import lfr_pkg::*;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    lfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lfr_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (8),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
